[src/mlfd_pkg.sv]
package mlfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 8'd1;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] msg_type;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] byte_index;
        logic              frame_ok;
        logic              last;
    } t_result;

endpackage

[src/mlfd_core.sv]
module mlfd_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic                      i_kind,
    input  logic [mlfd_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic [mlfd_pkg::BYTE_W-1:0] i_start_marker,
    input  logic [mlfd_pkg::BYTE_W-1:0] i_end_marker,
    output logic                      o_res_valid,
    output mlfd_pkg::t_result         o_res
);
    import mlfd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SIZE    = 3'd1,
        PH_TYPE    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_END     = 3'd4
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_size, n_size;
    logic [BYTE_W-1:0] r_type, n_type;
    logic [BYTE_W-1:0] r_count, n_count;
    logic              n_res_valid;
    t_result           n_res;
    logic              in_frame;
    logic [BYTE_W:0]   count_next;

    assign in_frame   = (r_phase == PH_SIZE) || (r_phase == PH_TYPE) ||
                        (r_phase == PH_PAYLOAD) || (r_phase == PH_END);
    assign count_next = {1'b0, r_count} + {{BYTE_W{1'b0}}, 1'b1};

    always_comb begin
        n_phase     = r_phase;
        n_size      = r_size;
        n_type      = r_type;
        n_count     = r_count;
        n_res_valid = 1'b0;
        n_res       = '{msg_type: r_type, payload_byte: '0, byte_index: r_count,
                        frame_ok: 1'b0, last: 1'b1};
        if (i_kind == KIND_FLUSH) begin
            n_res_valid = in_frame;
            n_phase     = PH_HUNT;
            n_size      = '0;
            n_type      = '0;
            n_count     = '0;
        end else begin
            unique case (r_phase)
                PH_SIZE: begin
                    n_size  = i_rx_byte;
                    n_type  = '0;
                    n_count = '0;
                    n_phase = (i_rx_byte == '0) ? PH_END : PH_TYPE;
                end
                PH_TYPE: begin
                    n_type  = i_rx_byte;
                    n_phase = (r_size > 8'd1) ? PH_PAYLOAD : PH_END;
                end
                PH_PAYLOAD: begin
                    n_res_valid        = 1'b1;
                    n_res.payload_byte = i_rx_byte;
                    n_res.last         = 1'b0;
                    n_count            = count_next[BYTE_W-1:0];
                    if ((count_next + {{BYTE_W{1'b0}}, 1'b1}) >= {1'b0, r_size}) begin
                        n_phase = PH_END;
                    end
                end
                PH_END: begin
                    n_res_valid    = 1'b1;
                    n_res.frame_ok = (i_rx_byte == i_end_marker);
                    n_phase        = PH_HUNT;
                    n_size         = '0;
                    n_type         = '0;
                    n_count        = '0;
                end
                default: begin
                    n_phase = (i_rx_byte == i_start_marker) ? PH_SIZE : PH_HUNT;
                    n_size  = '0;
                    n_type  = '0;
                    n_count = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_size      <= '0;
            r_type      <= '0;
            r_count     <= '0;
            o_res_valid <= 1'b0;
        end else begin
            o_res_valid <= i_accept && n_res_valid;
            if (i_accept) begin
                r_phase <= n_phase;
                r_size  <= n_size;
                r_type  <= n_type;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            o_res <= n_res;
        end
    end

endmodule

[src/marker_length_frame_deframer.sv]
// Start/length/end-marker deframer. One word (received byte or flush) is taken
// per clock while o_in_ready is high. Per-byte work is one registered state update
// followed by a two-entry output buffer. o_in_ready drops while the second entry
// is in use, or while a result is arriving and the output register holds one
// that downstream does not take in that cycle, so o_in_ready follows i_out_ready
// combinationally.
// Write start/end markers through the cfg port only while the block is idle.
module marker_length_frame_deframer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_kind,
    input  logic [mlfd_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [mlfd_pkg::BYTE_W-1:0]    o_msg_type,
    output logic [mlfd_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic [mlfd_pkg::BYTE_W-1:0]    o_byte_index,
    output logic                           o_frame_ok,
    output logic                           o_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mlfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mlfd_pkg::BYTE_W-1:0]    i_cfg_data
);
    import mlfd_pkg::*;

    logic [BYTE_W-1:0] r_start_marker;
    logic [BYTE_W-1:0] r_end_marker;
    logic              accept;
    logic              pop;
    logic              res_valid;
    t_result           res;
    logic              r_out_valid;
    t_result           r_out;
    logic              r_skid_valid;
    t_result           r_skid;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid && !(res_valid && r_out_valid && !i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign pop         = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= '0;
            r_end_marker   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_START_MARKER: r_start_marker <= i_cfg_data;
                CFG_END_MARKER:   r_end_marker   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mlfd_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_kind         (i_kind),
        .i_rx_byte      (i_rx_byte),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || pop) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_msg_type     = r_out.msg_type;
    assign o_payload_byte = r_out.payload_byte;
    assign o_byte_index   = r_out.byte_index;
    assign o_frame_ok     = r_out.frame_ok;
    assign o_last         = r_out.last;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_ok_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_ok) |-> o_last)
        else $error("frame_ok set on a payload word");

    a_payload_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_byte_index != 8'hFF))
        else $error("payload index out of range");

    a_result_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> $past(accept))
        else $error("result without an accepted word");

    a_result_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !r_skid_valid)
        else $error("result arrived while both entries were full");
`endif

endmodule
